>>> design/ile_pkg.sv
package ile_pkg;

    localparam int VAL_W     = 32;
    localparam int CMD_W     = 3;
    localparam int POS_IN_W  = 7;
    localparam int LEN_W     = 7;
    localparam int STAT_W    = 2;
    localparam int CTL_POS_W = 11;
    localparam int SEG_N     = 32;

    localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TAIL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_AT     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef logic [VAL_W-1:0] t_val;

    typedef struct packed {
        logic                 ins;
        logic                 del;
        logic [CTL_POS_W-1:0] pos;
        t_val                 value;
    } t_cell_ctl;

endpackage

>>> design/ile_cmd_if.sv
interface ile_cmd_if;
    import ile_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic [POS_IN_W-1:0]        position;
    logic signed [VAL_W-1:0]    value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

>>> design/ile_rsp_if.sv
interface ile_rsp_if;
    import ile_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VAL_W-1:0]    read_value;
    logic                       hit;
    logic [STAT_W-1:0]          status;
    logic [LEN_W-1:0]           length;

    modport source (output valid, output read_value, output hit, output status,
                    output length, input ready);
    modport sink   (input valid, input read_value, input hit, input status,
                    input length, output ready);
endinterface

>>> design/indexed_list_engine.sv
// Ordered list of up to DEPTH signed 32-bit values held in a row of cells.
// Command channel i_cmd: command (read, insert head, insert tail, insert at
// position, delete at position), position and value, taken on valid & ready.
// Response channel o_rsp: read_value, hit, status and the length after the
// request, one response per request, in order.
// Pipeline: on acceptance every cell updates in parallel and the read taps,
// ORed within groups of 32 cells, are captured in a stage register; the
// output register then takes the OR of the group results. A new request can
// be taken every cycle while responses drain.
// When the receiver stalls, the response holds in the output register and
// one more request may enter the stage register; further requests wait.
// Reset (synchronous, active low) empties the list and drops pending
// responses; stored values are not cleared, as only entries below the
// length are ever read.
module indexed_list_engine
    import ile_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ile_cmd_if.sink   i_cmd,
    ile_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PW    = (CNT_W > POS_IN_W) ? CNT_W : POS_IN_W;
    localparam int NSEG  = (DEPTH + SEG_N - 1) / SEG_N;

    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_s1_valid;
    t_val              r_s1_seg [NSEG];
    logic              r_s1_hit;
    logic [STAT_W-1:0] r_s1_status;
    logic [LEN_W-1:0]  r_s1_len;
    logic              r_out_valid;
    t_val              r_out_value;
    logic              r_out_hit;
    logic [STAT_W-1:0] r_out_status;
    logic [LEN_W-1:0]  r_out_len;

    logic              acc, load_out;
    logic [PW-1:0]     pos_x, cnt_x, n_cnt_x;
    logic              full, do_ins, do_del, n_hit;
    logic [PW-1:0]     ins_pos;
    logic [STAT_W-1:0] n_status;
    t_cell_ctl         ctl;
    t_val              cell_q   [DEPTH];
    t_val              cell_tap [NSEG*SEG_N];
    t_val              seg_or   [NSEG];
    t_val              all_or;

    assign load_out    = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_cmd.ready = !r_s1_valid || !r_out_valid || o_rsp.ready;
    assign acc         = i_cmd.valid && i_cmd.ready;

    assign pos_x = PW'(i_cmd.position);
    assign cnt_x = PW'(r_count);
    assign full  = (cnt_x == PW'(DEPTH));

    always_comb begin
        do_ins   = 1'b0;
        do_del   = 1'b0;
        n_hit    = 1'b0;
        ins_pos  = pos_x;
        n_status = ST_DONE;
        unique case (i_cmd.command)
            CMD_READ: begin
                if (pos_x < cnt_x) n_hit = 1'b1;
                else n_status = ST_RANGE;
            end
            CMD_HEAD: begin
                ins_pos = '0;
                if (full) n_status = ST_FULL;
                else do_ins = 1'b1;
            end
            CMD_TAIL: begin
                ins_pos = cnt_x;
                if (full) n_status = ST_FULL;
                else do_ins = 1'b1;
            end
            CMD_AT: begin
                if (pos_x > cnt_x) n_status = ST_RANGE;
                else if (full) n_status = ST_FULL;
                else do_ins = 1'b1;
            end
            CMD_DELETE: begin
                if (pos_x < cnt_x) do_del = 1'b1;
                else n_status = ST_RANGE;
            end
            default: n_status = ST_RANGE;
        endcase
    end

    always_comb begin
        n_cnt_x = cnt_x;
        if (do_ins) n_cnt_x = cnt_x + PW'(1);
        else if (do_del) n_cnt_x = cnt_x - PW'(1);
        n_count = CNT_W'(n_cnt_x);
    end

    always_comb begin
        ctl.ins   = acc && do_ins;
        ctl.del   = acc && do_del;
        ctl.pos   = CTL_POS_W'(ins_pos);
        ctl.value = i_cmd.value;
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_val prev_v, next_v;
        if (gi == 0) begin : g_first
            assign prev_v = cell_q[gi];
        end else begin : g_mid
            assign prev_v = cell_q[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign next_v = cell_q[gi];
        end else begin : g_inner
            assign next_v = cell_q[gi+1];
        end
        ile_cell #(.IDX(gi)) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_prev (prev_v),
            .i_next (next_v),
            .o_q    (cell_q[gi]),
            .o_tap  (cell_tap[gi])
        );
    end

    for (genvar gp = DEPTH; gp < NSEG*SEG_N; gp++) begin : g_pad
        assign cell_tap[gp] = '0;
    end

    for (genvar gs = 0; gs < NSEG; gs++) begin : g_seg
        always_comb begin
            seg_or[gs] = '0;
            for (int k = 0; k < SEG_N; k++) begin
                seg_or[gs] = seg_or[gs] | cell_tap[gs*SEG_N + k];
            end
        end
    end

    always_comb begin
        all_or = '0;
        for (int s = 0; s < NSEG; s++) begin
            all_or = all_or | r_s1_seg[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_count    <= n_count;
                r_s1_valid <= 1'b1;
            end else if (load_out) begin
                r_s1_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_seg    <= seg_or;
            r_s1_hit    <= n_hit;
            r_s1_status <= n_status;
            r_s1_len    <= n_cnt_x[LEN_W-1:0];
        end
        if (load_out) begin
            r_out_value  <= r_s1_hit ? all_or : '1;
            r_out_hit    <= r_s1_hit;
            r_out_status <= r_s1_status;
            r_out_len    <= r_s1_len;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_out_value;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.length     = r_out_len;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_count) <= PW'(DEPTH))
        else $error("list length beyond capacity");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_count))
        else $error("length changed without a request");

    a_hit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.hit) |-> (o_rsp.status == ST_DONE))
        else $error("hit with a failing status");

    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.hit) |-> (o_rsp.read_value == '1))
        else $error("miss without all-ones value");

endmodule

>>> design/ile_cell.sv
module ile_cell
    import ile_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_val      i_prev,
    input  t_val      i_next,
    output t_val      o_q,
    output t_val      o_tap
);

    localparam logic [CTL_POS_W-1:0] MY_IDX = CTL_POS_W'(IDX);

    t_val r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && (MY_IDX > i_ctl.pos)) begin
            r_q <= i_prev;
        end else if (i_ctl.ins && (MY_IDX == i_ctl.pos)) begin
            r_q <= i_ctl.value;
        end else if (i_ctl.del && (MY_IDX >= i_ctl.pos)) begin
            r_q <= i_next;
        end
    end

    assign o_q   = r_q;
    assign o_tap = (MY_IDX == i_ctl.pos) ? r_q : '0;

endmodule

>>> verif/indexed_list_engine_tb.sv
module indexed_list_engine_tb;
    import ile_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH    = 64;
    localparam int POS_MAX       = (1 << POS_IN_W) - 1;
    localparam int CMD_UNUSED_LO = CMD_DELETE + 1;
    localparam int CMD_UNUSED_HI = (1 << CMD_W) - 1;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_OFF      = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PRINT_LIMIT   = 40;
    localparam t_val MISS_VALUE  = '1;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic                    hit;
        logic [STAT_W-1:0]       status;
        logic [LEN_W-1:0]        length;
    } t_list_reply;

    logic i_clk;
    logic i_rst_n;

    ile_cmd_if cmd_ch();
    ile_rsp_if rsp_ch();

    indexed_list_engine #(
        .DEPTH (LIST_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    t_val        list_mem [LIST_DEPTH];
    int unsigned list_len;
    t_list_reply pending_replies [$];

    int mismatch_count;
    int idle_cycles;
    int tx_count;
    int rx_count;
    bit tx_burst;
    bit rx_burst;
    bit pressure_on;
    int rx_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [STAT_W-1:0] place_value(input int unsigned at, input t_val val);
        if (at > list_len)
            return ST_RANGE;
        if (list_len >= LIST_DEPTH)
            return ST_FULL;
        for (int unsigned i = list_len; i > at; i--)
            list_mem[i] = list_mem[i-1];
        list_mem[at] = val;
        list_len++;
        return ST_DONE;
    endfunction

    function automatic t_list_reply apply_list_request(input logic [CMD_W-1:0] op,
                                                       input logic [POS_IN_W-1:0] pos,
                                                       input t_val val);
        t_list_reply r;
        int unsigned p;
        p            = 32'(pos);
        r.read_value = MISS_VALUE;
        r.hit        = 1'b0;
        r.status     = ST_DONE;
        case (op)
            CMD_READ: begin
                if (p < list_len) begin
                    r.read_value = list_mem[p];
                    r.hit        = 1'b1;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            CMD_HEAD:   r.status = place_value(0, val);
            CMD_TAIL:   r.status = place_value(list_len, val);
            CMD_AT:     r.status = place_value(p, val);
            CMD_DELETE: begin
                if (p < list_len) begin
                    for (int unsigned i = p; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default:    r.status = ST_RANGE;
        endcase
        r.length = LEN_W'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t %s: got %0h, expected %0h", $time, field, got, want);
    endtask

    task automatic check_reply();
        t_list_reply want;
        if (pending_replies.size() == 0) begin
            report_mismatch("reply with no request outstanding", VAL_W'(rsp_ch.length), '0);
            return;
        end
        want = pending_replies.pop_front();
        if (rsp_ch.read_value !== want.read_value)
            report_mismatch("read_value", rsp_ch.read_value, want.read_value);
        if (rsp_ch.hit !== want.hit)
            report_mismatch("hit", VAL_W'(rsp_ch.hit), VAL_W'(want.hit));
        if (rsp_ch.status !== want.status)
            report_mismatch("status", VAL_W'(rsp_ch.status), VAL_W'(want.status));
        if (rsp_ch.length !== want.length)
            report_mismatch("length", VAL_W'(rsp_ch.length), VAL_W'(want.length));
    endtask

    task automatic send_request(input logic [CMD_W-1:0] op, input int unsigned pos,
                                input t_val val);
        int gap;
        gap = (tx_burst || pressure_on) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= op;
        cmd_ch.position <= pos[POS_IN_W-1:0];
        cmd_ch.value    <= val;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        pending_replies.push_back(apply_list_request(op, pos[POS_IN_W-1:0], val));
        tx_count++;
        if (tx_count % 40 == 0)
            tx_burst = ($urandom_range(0, 2) == 0);
    endtask

    function automatic int unsigned held_position();
        return (list_len > 0) ? $urandom_range(0, list_len - 1) : 0;
    endfunction

    task automatic send_random_requests(input int count);
        int unsigned r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 26)
                send_request(CMD_READ, held_position(), $urandom());
            else if (r < 36)
                send_request(CMD_HEAD, $urandom_range(0, POS_MAX), $urandom());
            else if (r < 46)
                send_request(CMD_TAIL, $urandom_range(0, POS_MAX), $urandom());
            else if (r < 58)
                send_request(CMD_AT, $urandom_range(0, list_len), $urandom());
            else if (r < 90)
                send_request(CMD_DELETE, held_position(), $urandom());
            else if (r < 96) begin
                case ($urandom_range(0, 2))
                    0:       send_request(CMD_READ, $urandom_range(list_len, POS_MAX), $urandom());
                    1:       send_request(CMD_AT, $urandom_range(list_len, POS_MAX), $urandom());
                    default: send_request(CMD_DELETE, $urandom_range(list_len, POS_MAX),
                                          $urandom());
                endcase
            end else begin
                send_request(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                             $urandom_range(0, POS_MAX), $urandom());
            end
        end
    endtask

    task automatic test_empty_list();
        send_request(CMD_READ, 0, $urandom());
        send_request(CMD_READ, POS_MAX, $urandom());
        send_request(CMD_DELETE, 0, $urandom());
        send_request(CMD_AT, 1, $urandom());
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
            send_request(CMD_W'(c), $urandom_range(0, POS_MAX), $urandom());
    endtask

    task automatic test_insert_variants();
        send_request(CMD_AT, 0, 32'h8000_0000);
        send_request(CMD_TAIL, 0, 32'h7FFF_FFFF);
        send_request(CMD_HEAD, 0, '0);
        send_request(CMD_AT, 1, '1);
        send_request(CMD_AT, 4, $urandom());
        send_request(CMD_AT, 6, $urandom());
        for (int p = 0; p <= 5; p++)
            send_request(CMD_READ, p, $urandom());
    endtask

    task automatic test_delete_positions();
        send_request(CMD_DELETE, 2, $urandom());
        send_request(CMD_DELETE, 0, $urandom());
        send_request(CMD_DELETE, list_len - 1, $urandom());
        send_request(CMD_DELETE, list_len, $urandom());
        send_request(CMD_READ, 0, $urandom());
        send_request(CMD_READ, 1, $urandom());
    endtask

    task automatic test_fill_and_drain();
        repeat (3) begin
            while (list_len < LIST_DEPTH) begin
                case ($urandom_range(0, 4))
                    0:       send_request(CMD_HEAD, $urandom_range(0, POS_MAX), $urandom());
                    1:       send_request(CMD_TAIL, $urandom_range(0, POS_MAX), $urandom());
                    4:       send_request(CMD_READ, $urandom_range(0, list_len), $urandom());
                    default: send_request(CMD_AT, $urandom_range(0, list_len), $urandom());
                endcase
            end
            send_request(CMD_HEAD, $urandom_range(0, POS_MAX), $urandom());
            send_request(CMD_TAIL, $urandom_range(0, POS_MAX), $urandom());
            send_request(CMD_AT, $urandom_range(0, LIST_DEPTH), $urandom());
            send_request(CMD_AT, $urandom_range(LIST_DEPTH + 1, POS_MAX), $urandom());
            send_request(CMD_READ, LIST_DEPTH - 1, $urandom());
            send_request(CMD_READ, LIST_DEPTH, $urandom());
            send_request(CMD_DELETE, $urandom_range(LIST_DEPTH, POS_MAX), $urandom());
            while (list_len > 0) begin
                if ($urandom_range(0, 3) == 0)
                    send_request(CMD_READ, held_position(), $urandom());
                else
                    send_request(CMD_DELETE, held_position(), $urandom());
            end
        end
    endtask

    task automatic test_random_mix();
        send_random_requests(550);
    endtask

    task automatic test_backpressure();
        pressure_on    = 1'b1;
        rx_hold_cycles = HOLD_OFF;
        send_random_requests(160);
        pressure_on    = 1'b0;
    endtask

    initial begin : reply_sink
        int gap;
        rsp_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (rx_hold_cycles > 0)
                gap = rx_hold_cycles;
            else
                gap = rx_burst ? 0 : $urandom_range(0, 15);
            rx_hold_cycles = 0;
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            check_reply();
            rx_count++;
            if (rx_count % 40 == 0)
                rx_burst = ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.command  <= CMD_READ;
        cmd_ch.position <= '0;
        cmd_ch.value    <= '0;
        list_len        = 0;
        mismatch_count  = 0;
        tx_count        = 0;
        rx_count        = 0;
        tx_burst        = 1'b0;
        rx_burst        = 1'b0;
        pressure_on     = 1'b0;
        rx_hold_cycles  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_insert_variants();
        test_delete_positions();
        test_fill_and_drain();
        test_random_mix();
        test_backpressure();

        cmd_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
